### design/plts_pkg.sv
package plts_pkg;

    // Item action codes
    localparam logic [1:0] ACT_CMD   = 2'd0;
    localparam logic [1:0] ACT_ALARM = 2'd1;
    localparam logic [1:0] ACT_WDOG  = 2'd2;

    // Alarm operation codes
    localparam logic [1:0] ALARM_LEAVE = 2'd0;
    localparam logic [1:0] ALARM_ARM   = 2'd1;
    localparam logic [1:0] ALARM_OFF   = 2'd2;

    // Configuration register map (index = paddr[4:2])
    localparam int unsigned CFG_AW = 5;
    localparam logic [2:0] REG_MIN_PHASE   = 3'd0;
    localparam logic [2:0] REG_START_LIMIT = 3'd1;
    localparam logic [2:0] REG_STOP_LIMIT  = 3'd2;
    localparam logic [2:0] REG_START_GUARD = 3'd3;
    localparam logic [2:0] REG_SHUT_TMO    = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_MIN_PHASE   = 16'd400;
    localparam logic [19:0] RST_START_LIMIT = 20'd100000;
    localparam logic [19:0] RST_STOP_LIMIT  = 20'd200000;
    localparam logic [15:0] RST_START_GUARD = 16'd2000;
    localparam logic [23:0] RST_SHUT_TMO    = 24'd600000;

    // Period multiple of 20 built as (p << 4) + (p << 2)
    localparam int unsigned MULT_SHIFT_HI = 4;
    localparam int unsigned MULT_SHIFT_LO = 2;

    // Phase codes
    localparam logic [1:0] PH_ZERO = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [63:0] cmd_zero_time;
        logic signed [31:0] cmd_period;
        logic [31:0]        cmd_offset;
        logic [15:0]        cmd_level_a;
        logic [15:0]        cmd_level_b;
        logic signed [63:0] synced_now;
        logic [62:0]        local_now;
        logic               sync_ok;
    } t_in_item;

    typedef struct packed {
        logic               throttle_write;
        logic [15:0]        throttle;
        logic [1:0]         alarm_op;
        logic signed [31:0] alarm_delay;
        logic               led_write;
        logic               led_level;
    } t_out_item;

    typedef struct packed {
        logic [15:0] min_phase_us;
        logic [19:0] start_period_limit;
        logic [19:0] stop_period_limit;
        logic [15:0] start_guard_us;
        logic [23:0] shutdown_timeout_us;
    } t_cfg;

endpackage

### design/plts_alu.sv
module plts_alu (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic        i_sub,
    output logic [63:0] o_sum,
    output logic        o_carry
);

    logic [63:0] w_b;
    logic [64:0] w_full;

    // Add or subtract; carry out set means no borrow on subtract
    assign w_b     = i_sub ? ~i_b : i_b;
    assign w_full  = {1'b0, i_a} + {1'b0, w_b} + {64'd0, i_sub};
    assign o_sum   = w_full[63:0];
    assign o_carry = w_full[64];

endmodule

### design/plts_regs.sv
module plts_regs
    import plts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[CFG_AW-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_phase_us        <= RST_MIN_PHASE;
            r_cfg.start_period_limit  <= RST_START_LIMIT;
            r_cfg.stop_period_limit   <= RST_STOP_LIMIT;
            r_cfg.start_guard_us      <= RST_START_GUARD;
            r_cfg.shutdown_timeout_us <= RST_SHUT_TMO;
        end else if (w_wr) begin
            case (w_idx)
                REG_MIN_PHASE:   r_cfg.min_phase_us        <= pwdata[15:0];
                REG_START_LIMIT: r_cfg.start_period_limit  <= pwdata[19:0];
                REG_STOP_LIMIT:  r_cfg.stop_period_limit   <= pwdata[19:0];
                REG_START_GUARD: r_cfg.start_guard_us      <= pwdata[15:0];
                REG_SHUT_TMO:    r_cfg.shutdown_timeout_us <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_MIN_PHASE:   prdata = {16'd0, r_cfg.min_phase_us};
            REG_START_LIMIT: prdata = {12'd0, r_cfg.start_period_limit};
            REG_STOP_LIMIT:  prdata = {12'd0, r_cfg.stop_period_limit};
            REG_START_GUARD: prdata = {16'd0, r_cfg.start_guard_us};
            REG_SHUT_TMO:    prdata = {8'd0, r_cfg.shutdown_timeout_us};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

### design/phase_locked_throttle_scheduler.sv
// A starting command or a resyncing alarm goes through decode, the phase sum (6 steps), 64 remainder
// steps, fix, finish and output; a resync onto a zero period skips the remainder steps; a watchdog item
// goes through decode, the silence check and output, any other item through decode and output.
// Flow: one item at a time, the next accepted in the cycle after the result is registered; a stalled
// output holds the result and the sequencer, and the shared 64-bit adder sets the pace.
// Reset: synchronous active low; scheduler stopped, phase two, commands and registers reset.
module phase_locked_throttle_scheduler
    import plts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_DECODE = 8'b00000010,
        S_SUM    = 8'b00000100,
        S_DIV    = 8'b00001000,
        S_FIX    = 8'b00010000,
        S_FINISH = 8'b00100000,
        S_WDOG   = 8'b01000000,
        S_OUT    = 8'b10000000
    } t_state;

    t_cfg w_cfg;

    t_state r_state;
    logic [5:0] r_cnt;
    t_in_item r_item;
    logic r_mode_cmd;

    // Scheduler state
    logic signed [63:0] r_lat_zero;
    logic signed [31:0] r_lat_period;
    logic [31:0]        r_lat_offset;
    logic [15:0]        r_lat_a;
    logic [15:0]        r_lat_b;
    logic signed [63:0] r_act_zero;
    logic signed [31:0] r_act_period;
    logic [31:0]        r_act_offset;
    logic [15:0]        r_act_a;
    logic [15:0]        r_act_b;
    logic [1:0]         r_phase;
    logic               r_running;
    logic [62:0]        r_last_update;

    // Datapath
    logic [63:0] r_acc;
    logic        r_sign;
    logic [31:0] r_dvs;
    logic [32:0] r_rem;
    logic [32:0] r_res;
    t_out_item   r_pend;
    t_out_item   r_out_item;
    logic        r_out_valid;

    logic [63:0] w_alu_a;
    logic [63:0] w_alu_b;
    logic        w_alu_sub;
    logic [63:0] w_alu_sum;
    logic        w_alu_carry;

    logic [63:0]        w_per64;
    logic [32:0]        w_rem_sh;
    logic signed [31:0] w_half;
    logic signed [34:0] w_half35;
    logic signed [34:0] w_half_off;
    logic signed [34:0] w_half_add_off;
    logic               w_ph1_ok;
    logic               w_led_gt;
    logic [19:0]        w_lim;
    logic               w_per_ok;
    logic               w_out_free;
    logic signed [31:0] w_next;
    logic               w_hi;
    logic               w_lo;
    logic               w_guard_lt;
    logic [16:0]        w_mid;
    logic               w_timeout;

    plts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    plts_alu u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .i_sub   (w_alu_sub),
        .o_sum   (w_alu_sum),
        .o_carry (w_alu_carry)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_per64  = {{32{r_act_period[31]}}, r_act_period};
    assign w_rem_sh = {r_rem[31:0], r_acc[63]};

    // Half period truncated toward zero
    assign w_half         = $signed(r_act_period + {31'd0, r_act_period[31]}) >>> 1;
    assign w_half35       = {{3{w_half[31]}}, w_half};
    assign w_half_off     = w_half35 - $signed({3'd0, r_act_offset});
    assign w_half_add_off = w_half35 + $signed({3'd0, r_act_offset});
    assign w_ph1_ok       = w_half_off > $signed({19'd0, w_cfg.min_phase_us});
    assign w_led_gt       = r_act_b > r_act_a;

    // Start/stop hysteresis on the command period
    assign w_lim    = r_running ? w_cfg.stop_period_limit : w_cfg.start_period_limit;
    assign w_per_ok = !r_item.cmd_period[31] && (r_item.cmd_period != 32'sd0)
                      && (r_item.cmd_period[30:0] < {11'd0, w_lim});

    // Resync alarm correction
    assign w_next = $signed(r_res[31:0]);
    assign w_hi   = $signed({{3{w_next[31]}}, w_next}) > w_half_add_off;
    assign w_lo   = w_next < $signed({16'd0, w_cfg.min_phase_us});

    // Start command guard and mid throttle
    assign w_guard_lt = $signed({r_res[32], r_res}) < $signed({18'd0, w_cfg.start_guard_us});
    assign w_mid      = {1'b0, r_act_a} + {1'b0, r_act_b};

    // Watchdog silence check on the registered difference
    assign w_timeout = (r_last_update != 63'd0) && !r_acc[63]
                       && ((|r_acc[62:24]) || (r_acc[23:0] >= w_cfg.shutdown_timeout_us));

    // Select operands of the shared adder
    always_comb begin
        w_alu_a   = 64'd0;
        w_alu_b   = 64'd0;
        w_alu_sub = 1'b0;
        case (r_state)
            S_SUM: begin
                case (r_cnt[2:0])
                    3'd0: begin
                        w_alu_a = r_act_zero;
                        w_alu_b = r_mode_cmd ? 64'd0 : {32'd0, r_act_offset};
                    end
                    3'd1: begin
                        w_alu_a = r_acc;
                        w_alu_b = {w_per64[63-MULT_SHIFT_HI:0], {MULT_SHIFT_HI{1'b0}}};
                    end
                    3'd2: begin
                        w_alu_a = r_acc;
                        w_alu_b = {w_per64[63-MULT_SHIFT_LO:0], {MULT_SHIFT_LO{1'b0}}};
                    end
                    3'd3: begin
                        w_alu_a   = r_acc;
                        w_alu_b   = r_item.synced_now;
                        w_alu_sub = 1'b1;
                    end
                    3'd4: begin
                        w_alu_b   = r_acc;
                        w_alu_sub = 1'b1;
                    end
                    default: begin
                        w_alu_b   = w_per64;
                        w_alu_sub = 1'b1;
                    end
                endcase
            end
            S_DIV: begin
                w_alu_a   = {31'd0, w_rem_sh};
                w_alu_b   = {32'd0, r_dvs};
                w_alu_sub = 1'b1;
            end
            S_FIX: begin
                w_alu_b   = {31'd0, r_rem};
                w_alu_sub = 1'b1;
            end
            S_WDOG: begin
                w_alu_a   = {1'b0, r_item.local_now};
                w_alu_b   = {1'b0, r_last_update};
                w_alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer, scheduler state and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= 6'd0;
            r_out_valid   <= 1'b0;
            r_lat_zero    <= 64'sd0;
            r_lat_period  <= 32'sd0;
            r_lat_offset  <= 32'd0;
            r_lat_a       <= 16'd0;
            r_lat_b       <= 16'd0;
            r_act_zero    <= 64'sd0;
            r_act_period  <= 32'sd0;
            r_act_offset  <= 32'd0;
            r_act_a       <= 16'd0;
            r_act_b       <= 16'd0;
            r_phase       <= PH_TWO;
            r_running     <= 1'b0;
            r_last_update <= 63'd0;
        end else begin
            // Drop the output item once taken
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_state <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    r_pend     <= '0;
                    r_cnt      <= 6'd0;
                    r_state    <= S_OUT;
                    r_mode_cmd <= 1'b0;
                    case (r_item.action)
                        ACT_CMD: begin
                            r_lat_zero    <= r_item.cmd_zero_time;
                            r_lat_period  <= r_item.cmd_period;
                            r_lat_offset  <= r_item.cmd_offset;
                            r_lat_a       <= r_item.cmd_level_a;
                            r_lat_b       <= r_item.cmd_level_b;
                            r_last_update <= r_item.local_now;
                            if (r_item.sync_ok) begin
                                if (!w_per_ok) begin
                                    r_pend.throttle_write <= 1'b1;
                                    r_pend.alarm_op       <= ALARM_OFF;
                                    r_running             <= 1'b0;
                                end else if (!r_running) begin
                                    r_act_zero   <= r_item.cmd_zero_time;
                                    r_act_period <= r_item.cmd_period;
                                    r_act_offset <= r_item.cmd_offset;
                                    r_act_a      <= r_item.cmd_level_a;
                                    r_act_b      <= r_item.cmd_level_b;
                                    r_phase      <= PH_TWO;
                                    r_running    <= 1'b1;
                                    r_mode_cmd   <= 1'b1;
                                    r_state      <= S_SUM;
                                end
                            end
                        end
                        ACT_ALARM: begin
                            if (r_running) begin
                                if (r_phase == PH_ZERO) begin
                                    r_pend.throttle_write <= 1'b1;
                                    r_pend.throttle       <= r_act_b;
                                    r_pend.alarm_op       <= ALARM_ARM;
                                    r_pend.alarm_delay    <= w_half;
                                    r_pend.led_write      <= 1'b1;
                                    r_pend.led_level      <= !w_led_gt;
                                    r_phase               <= PH_ONE;
                                end else if (r_phase == PH_ONE && w_ph1_ok) begin
                                    r_pend.throttle_write <= 1'b1;
                                    r_pend.throttle       <= r_act_a;
                                    r_pend.alarm_op       <= ALARM_ARM;
                                    r_pend.alarm_delay    <= w_half_off[31:0];
                                    r_pend.led_write      <= 1'b1;
                                    r_pend.led_level      <= w_led_gt;
                                    r_phase               <= PH_TWO;
                                end else begin
                                    // Resync to the latest command
                                    r_act_zero   <= r_lat_zero;
                                    r_act_period <= r_lat_period;
                                    r_act_offset <= r_lat_offset;
                                    r_act_a      <= r_lat_a;
                                    r_act_b      <= r_lat_b;
                                    r_phase      <= PH_TWO;
                                    r_state      <= S_SUM;
                                end
                            end
                        end
                        ACT_WDOG: begin
                            r_state <= S_WDOG;
                        end
                        default: ;
                    endcase
                end

                S_SUM: begin
                    r_cnt <= r_cnt + 6'd1;
                    case (r_cnt[2:0])
                        3'd4: begin
                            // Take the dividend magnitude
                            r_sign <= r_acc[63];
                            if (r_acc[63]) begin
                                r_acc <= w_alu_sum;
                            end
                        end
                        3'd5: begin
                            r_dvs <= r_act_period[31] ? w_alu_sum[31:0] : r_act_period;
                            r_cnt <= 6'd0;
                            if (r_act_period == 32'sd0) begin
                                // Remainder by zero leaves the dividend
                                r_rem   <= r_acc[32:0];
                                r_state <= S_FIX;
                            end else begin
                                r_rem   <= 33'd0;
                                r_state <= S_DIV;
                            end
                        end
                        default: begin
                            r_acc <= w_alu_sum;
                        end
                    endcase
                end

                S_DIV: begin
                    // One restoring remainder step per cycle
                    r_acc <= {r_acc[62:0], 1'b0};
                    r_rem <= w_alu_carry ? w_alu_sum[32:0] : w_rem_sh;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_FIX;
                    end
                end

                S_FIX: begin
                    // Remainder takes the dividend's sign
                    r_res   <= r_sign ? w_alu_sum[32:0] : r_rem;
                    r_state <= S_FINISH;
                end

                S_FINISH: begin
                    r_pend                <= '0;
                    r_pend.throttle_write <= 1'b1;
                    r_pend.alarm_op       <= ALARM_ARM;
                    r_state               <= S_OUT;
                    if (r_mode_cmd) begin
                        r_pend.throttle    <= w_mid[16:1];
                        r_pend.alarm_delay <= w_guard_lt ? r_act_period : r_res[31:0];
                    end else begin
                        r_pend.led_write <= 1'b1;
                        if (w_hi || w_lo) begin
                            r_pend.throttle    <= r_act_b;
                            r_pend.alarm_delay <= w_hi ? (w_next - w_half) : (w_next + w_half);
                            r_pend.led_level   <= !w_led_gt;
                            r_phase            <= PH_ONE;
                        end else begin
                            r_pend.throttle    <= r_act_a;
                            r_pend.alarm_delay <= w_next;
                            r_pend.led_level   <= w_led_gt;
                            r_phase            <= PH_ZERO;
                        end
                    end
                end

                S_WDOG: begin
                    if (r_cnt == 6'd0) begin
                        r_acc <= w_alu_sum;
                        r_cnt <= 6'd1;
                    end else begin
                        r_state <= S_OUT;
                        if (w_timeout || !r_item.sync_ok) begin
                            r_pend.throttle_write <= 1'b1;
                            r_pend.alarm_op       <= ALARM_OFF;
                            r_last_update         <= 63'd0;
                            r_running             <= 1'b0;
                        end
                    end
                end

                S_OUT: begin
                    // Hand the item to the output register when it is free
                    if (w_out_free) begin
                        r_out_item  <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench
    import plts_pkg::*;
();

    // Action code that the block has no use for
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [63:0] zero_at;
        logic signed [31:0] period;
        logic [31:0]        offset;
        logic [15:0]        level_a;
        logic [15:0]        level_b;
    } t_sched_cmd;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_item = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_item;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    phase_locked_throttle_scheduler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Scheduler shadow state
    t_cfg               sched_cfg;
    t_sched_cmd         latest_cmd;
    t_sched_cmd         active_cmd;
    logic [1:0]         sched_phase;
    logic               sched_running;
    logic [63:0]        last_update;

    t_out_item          expected_results[$];
    int                 mismatch_count = 0;
    int                 items_sent = 0;
    int                 results_seen = 0;
    int                 starts_seen = 0;
    int                 resyncs_seen = 0;
    int                 shutdowns_seen = 0;
    int                 cfg_writes = 0;
    bit                 idle_enable = 1'b1;
    bit                 hold_req = 1'b0;
    logic signed [63:0] sync_clock = 64'sd0;
    logic [62:0]        local_clock = 63'd1000;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // Truncated remainder; a zero divisor passes the dividend through
    function automatic logic signed [63:0] trunc_rem(input logic signed [63:0] num,
                                                     input logic signed [63:0] den);
        logic [63:0] mag_n;
        logic [63:0] mag_d;
        logic [63:0] mag_r;
        if (den == 64'sd0) begin
            return num;
        end
        mag_n = num[63] ? -num : num;
        mag_d = den[63] ? -den : den;
        mag_r = mag_n % mag_d;
        return num[63] ? -mag_r : mag_r;
    endfunction

    // Wrapping sum zero + offset + 20 * period - now
    function automatic logic signed [63:0] phase_sum(input logic [63:0] zero,
                                                     input logic [31:0] off,
                                                     input logic [31:0] per,
                                                     input logic [63:0] now);
        logic [63:0] per20;
        per20 = sext32(per) * 64'd20;
        return zero + {32'b0, off} + per20 - now;
    endfunction

    function automatic logic [1:0] phase_after(input logic [1:0] ph);
        case (ph)
            PH_ZERO: return PH_ONE;
            PH_ONE:  return PH_TWO;
            default: return PH_ZERO;
        endcase
    endfunction

    function automatic void reset_schedule();
        sched_cfg.min_phase_us        = RST_MIN_PHASE;
        sched_cfg.start_period_limit  = RST_START_LIMIT;
        sched_cfg.stop_period_limit   = RST_STOP_LIMIT;
        sched_cfg.start_guard_us      = RST_START_GUARD;
        sched_cfg.shutdown_timeout_us = RST_SHUT_TMO;
        latest_cmd    = '0;
        active_cmd    = '0;
        sched_phase   = PH_TWO;
        sched_running = 1'b0;
        last_update   = '0;
    endfunction

    // Advance the shadow scheduler by one item and return its result
    function automatic t_out_item predict_schedule(input t_in_item it);
        t_out_item          res;
        logic [19:0]        limit;
        logic [16:0]        lvl_sum;
        logic signed [63:0] per_s;
        logic signed [63:0] half;
        logic signed [63:0] next;
        logic signed [63:0] off_s;
        logic signed [63:0] minp_s;
        logic signed [63:0] tmo_s;
        res = '0;
        case (it.action)
            ACT_CMD: begin
                latest_cmd.zero_at = it.cmd_zero_time;
                latest_cmd.period  = it.cmd_period;
                latest_cmd.offset  = it.cmd_offset;
                latest_cmd.level_a = it.cmd_level_a;
                latest_cmd.level_b = it.cmd_level_b;
                last_update = {1'b0, it.local_now};
                if (it.sync_ok) begin
                    limit = sched_running ? sched_cfg.stop_period_limit
                                          : sched_cfg.start_period_limit;
                    if (!it.cmd_period[31] && it.cmd_period != 32'd0 &&
                        it.cmd_period[30:0] < {11'b0, limit}) begin
                        // start only from stopped; a running scheduler keeps going
                        if (!sched_running) begin
                            active_cmd = latest_cmd;
                            per_s = sext32(it.cmd_period);
                            next = trunc_rem(phase_sum(it.cmd_zero_time, 32'd0, it.cmd_period,
                                                       it.synced_now), per_s);
                            if (next < $signed({48'b0, sched_cfg.start_guard_us})) begin
                                next = per_s;
                            end
                            sched_phase   = PH_TWO;
                            sched_running = 1'b1;
                            lvl_sum = {1'b0, it.cmd_level_a} + {1'b0, it.cmd_level_b};
                            res.throttle_write = 1'b1;
                            res.throttle       = lvl_sum[16:1];
                            res.alarm_op       = ALARM_ARM;
                            res.alarm_delay    = next[31:0];
                            starts_seen++;
                        end
                    end else begin
                        res.throttle_write = 1'b1;
                        res.alarm_op       = ALARM_OFF;
                        sched_running      = 1'b0;
                    end
                end
            end
            ACT_ALARM: begin
                if (sched_running) begin
                    minp_s = $signed({48'b0, sched_cfg.min_phase_us});
                    half   = sext32(active_cmd.period) / 64'sd2;
                    off_s  = $signed({32'b0, active_cmd.offset});
                    if (sched_phase == PH_ZERO) begin
                        next         = half;
                        res.throttle = active_cmd.level_b;
                    end else if (sched_phase == PH_ONE && half - off_s > minp_s) begin
                        next         = half - off_s;
                        res.throttle = active_cmd.level_a;
                    end else begin
                        // resync to the latest command
                        sched_phase = PH_TWO;
                        active_cmd  = latest_cmd;
                        per_s = sext32(active_cmd.period);
                        half  = per_s / 64'sd2;
                        off_s = $signed({32'b0, active_cmd.offset});
                        next  = trunc_rem(phase_sum(active_cmd.zero_at, active_cmd.offset,
                                                    active_cmd.period, it.synced_now), per_s);
                        next  = sext32(next[31:0]);
                        res.throttle = active_cmd.level_a;
                        if (next > half + off_s) begin
                            next         = next - half;
                            res.throttle = active_cmd.level_b;
                            sched_phase  = PH_ZERO;
                        end else if (next < minp_s) begin
                            next         = next + half;
                            res.throttle = active_cmd.level_b;
                            sched_phase  = PH_ZERO;
                        end
                        resyncs_seen++;
                    end
                    res.throttle_write = 1'b1;
                    res.alarm_op       = ALARM_ARM;
                    res.alarm_delay    = next[31:0];
                    res.led_write      = 1'b1;
                    res.led_level      = (sched_phase == PH_ZERO) ^
                                         (active_cmd.level_b > active_cmd.level_a);
                    sched_phase = phase_after(sched_phase);
                end
            end
            ACT_WDOG: begin
                tmo_s = $signed({40'b0, sched_cfg.shutdown_timeout_us});
                if ((last_update != 64'd0 &&
                     $signed({1'b0, it.local_now} - last_update) >= tmo_s) || !it.sync_ok) begin
                    res.throttle_write = 1'b1;
                    res.alarm_op       = ALARM_OFF;
                    last_update        = '0;
                    sched_running      = 1'b0;
                    shutdowns_seen++;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_in_item mk_item(input logic [1:0] act, input logic [63:0] zero,
                                         input logic [31:0] per, input logic [31:0] off,
                                         input logic [15:0] lvl_a, input logic [15:0] lvl_b,
                                         input logic sync);
        t_in_item it;
        it.action        = act;
        it.cmd_zero_time = zero;
        it.cmd_period    = per;
        it.cmd_offset    = off;
        it.cmd_level_a   = lvl_a;
        it.cmd_level_b   = lvl_b;
        it.synced_now    = sync_clock;
        it.local_now     = local_clock;
        it.sync_ok       = sync;
        return it;
    endfunction

    // Item whose command fields are don't-care
    function automatic t_in_item tick_item(input logic [1:0] act, input logic sync);
        logic [31:0] lv;
        lv = $urandom;
        return mk_item(act, rand64(), $urandom, $urandom, lv[15:0], lv[31:16], sync);
    endfunction

    // Offer one item, hold it until accepted, then record its result
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        while (idle_enable && $urandom_range(99) < 36) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_schedule(it));
        items_sent++;
    endtask

    // Drop valid and let the block go quiet
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_PHASE:   sched_cfg.min_phase_us        = val[15:0];
            REG_START_LIMIT: sched_cfg.start_period_limit  = val[19:0];
            REG_STOP_LIMIT:  sched_cfg.stop_period_limit   = val[19:0];
            REG_START_GUARD: sched_cfg.start_guard_us      = val[15:0];
            REG_SHUT_TMO:    sched_cfg.shutdown_timeout_us = val[23:0];
            default: begin
            end
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(input logic [31:0] min_phase, input logic [31:0] start_lim,
                              input logic [31:0] stop_lim, input logic [31:0] guard,
                              input logic [31:0] tmo);
        write_cfg(REG_MIN_PHASE, min_phase);
        write_cfg(REG_START_LIMIT, start_lim);
        write_cfg(REG_STOP_LIMIT, stop_lim);
        write_cfg(REG_START_GUARD, guard);
        write_cfg(REG_SHUT_TMO, tmo);
    endtask

    // Mostly well-formed traffic on advancing clocks, with some edge periods and noise
    task automatic send_random_item();
        int          sel;
        logic [63:0] step;
        logic [31:0] per;
        logic [31:0] off;
        logic [31:0] lv;
        logic [31:0] lim;
        t_in_item    it;
        sel  = $urandom_range(99);
        lv   = $urandom;
        step = {32'b0, $urandom_range(40000)};
        sync_clock  = sync_clock + step;
        step = {32'b0, $urandom_range(40000)};
        local_clock = local_clock + step[62:0];
        if (sel < 14) begin
            per = $urandom_range(95000, 400);
            off = ($urandom_range(3) == 0) ? $urandom : $urandom_range(per / 2 + 500);
            step = {32'b0, $urandom_range(400000)};
            it = mk_item(ACT_CMD, sync_clock - step, per, off, lv[15:0], lv[31:16], 1'b1);
        end else if (sel < 70) begin
            it = tick_item(ACT_ALARM, $urandom_range(15) != 0);
        end else if (sel < 80) begin
            if ($urandom_range(3) == 0) begin
                local_clock = local_clock + {39'b0, sched_cfg.shutdown_timeout_us} +
                              63'($urandom_range(1000));
            end
            it = tick_item(ACT_WDOG, $urandom_range(9) != 0);
        end else if (sel < 88) begin
            lim = sched_running ? {12'b0, sched_cfg.stop_period_limit}
                                : {12'b0, sched_cfg.start_period_limit};
            case ($urandom_range(5))
                0: per = 32'd0;
                1: per = {1'b1, 31'($urandom)};
                2: per = lim - 32'd1;
                3: per = lim;
                4: per = lim + 32'd1;
                default: per = $urandom;
            endcase
            step = {32'b0, $urandom_range(400000)};
            it = mk_item(ACT_CMD, sync_clock - step, per, $urandom_range(per / 2 + 500),
                         lv[15:0], lv[31:16], $urandom_range(7) != 0);
        end else begin
            it = tick_item(lv[1:0], lv[2]);
            it.cmd_zero_time = rand64();
            it.synced_now    = rand64();
            step = rand64();
            it.local_now     = step[62:0];
        end
        send_item(it);
    endtask

    // Alarm, watchdog and unused action with the scheduler stopped
    task automatic test_idle_actions();
        send_item(tick_item(ACT_ALARM, 1'b1));
        send_item(tick_item(ACT_WDOG, 1'b1));
        send_item(tick_item(ACT_UNUSED, 1'b1));
        send_item(tick_item(ACT_WDOG, 1'b0));
    endtask

    // Commands with every field at its top and at its bottom
    task automatic test_field_extremes();
        t_in_item it;
        it = mk_item(ACT_CMD, 64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
                     16'hffff, 16'hffff, 1'b1);
        it.synced_now = 64'h7fff_ffff_ffff_ffff;
        it.local_now  = '1;
        send_item(it);
        it = mk_item(ACT_CMD, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'd0,
                     16'd0, 16'd0, 1'b1);
        it.synced_now = 64'h8000_0000_0000_0000;
        it.local_now  = '0;
        send_item(it);
    endtask

    // Start, hysteresis, stop and the start guard
    task automatic test_start_stop();
        sync_clock = 64'sd1_000_000;
        send_item(mk_item(ACT_CMD, sync_clock, 32'd50000, 32'd0, 16'd10, 16'd20, 1'b0));
        send_item(mk_item(ACT_CMD, sync_clock, 32'd100000, 32'd0, 16'd10, 16'd20, 1'b1));
        send_item(mk_item(ACT_CMD, sync_clock - 64'sd3000, 32'd50000, 32'd700,
                          16'd1001, 16'd3000, 1'b1));
        send_item(mk_item(ACT_CMD, sync_clock, 32'd150000, 32'd0, 16'd10, 16'd20, 1'b1));
        send_item(mk_item(ACT_CMD, sync_clock, 32'd200000, 32'd0, 16'd10, 16'd20, 1'b1));
        send_item(mk_item(ACT_CMD, sync_clock - 64'sd999_500, 32'd50000, 32'd0,
                          16'hffff, 16'hfffe, 1'b1));
    endtask

    // Walk the phases: plain resync, long and short remainders
    task automatic test_phase_cycle();
        sync_clock = 64'sd0;
        send_item(mk_item(ACT_CMD, 64'd0, 32'd10000, 32'd1000, 16'd100, 16'd900, 1'b1));
        sync_clock = 64'sd198000;
        send_item(tick_item(ACT_ALARM, 1'b1));
        send_item(tick_item(ACT_ALARM, 1'b1));
        send_item(tick_item(ACT_ALARM, 1'b1));
        sync_clock = 64'sd193000;
        send_item(tick_item(ACT_ALARM, 1'b1));
        send_item(tick_item(ACT_ALARM, 1'b1));
        sync_clock = 64'sd200900;
        send_item(tick_item(ACT_ALARM, 1'b1));
    endtask

    // Resync onto a zero period, then onto a negative one
    task automatic test_odd_periods();
        send_item(mk_item(ACT_CMD, rand64(), 32'd0, $urandom, 16'd5, 16'd6, 1'b0));
        send_item(tick_item(ACT_ALARM, 1'b1));
        send_item(tick_item(ACT_ALARM, 1'b1));
        send_item(mk_item(ACT_CMD, sync_clock + 64'sd12345, -32'sd7777, 32'd300,
                          16'd700, 16'd200, 1'b0));
        repeat (3) send_item(tick_item(ACT_ALARM, 1'b1));
    endtask

    // Command silence just under and exactly at the timeout
    task automatic test_watchdog();
        local_clock = 63'd5_000_000;
        send_item(mk_item(ACT_CMD, sync_clock, 32'd9000, 32'd10, 16'd1, 16'd2, 1'b0));
        local_clock = local_clock + {39'b0, sched_cfg.shutdown_timeout_us} - 63'd1;
        send_item(tick_item(ACT_WDOG, 1'b1));
        local_clock = local_clock + 63'd1;
        send_item(tick_item(ACT_WDOG, 1'b1));
    endtask

    // Traffic under the smallest and the largest register values
    task automatic test_config_extremes();
        set_config(32'd0, 32'd1, 32'd1, 32'd0, 32'd1);
        repeat (40) send_random_item();
        set_config(32'd65535, 32'd1048575, 32'd1048575, 32'd65535, 32'd16777215);
        repeat (40) send_random_item();
        set_config({16'b0, RST_MIN_PHASE}, {12'b0, RST_START_LIMIT}, {12'b0, RST_STOP_LIMIT},
                   {16'b0, RST_START_GUARD}, {8'b0, RST_SHUT_TMO});
    endtask

    // Hold the output off for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (12) send_random_item();
    endtask

    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 5; chunk++) begin
            if (chunk != 0) begin
                set_config($urandom_range(4000), $urandom_range(1048575, 1),
                           $urandom_range(1048575, 1), $urandom_range(65535),
                           $urandom_range(3000000, 1));
            end
            idle_enable = (chunk != 2);
            repeat (90) send_random_item();
        end
        idle_enable = 1'b1;
    endtask

    // Drive the output stall: random idling, or a counted hold-off on request
    initial begin : out_stall_drive
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold = 300;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idle_enable && ($urandom_range(99) < 36);
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, o_out_item);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("throttle_write", 64'(want.throttle_write),
                            64'(o_out_item.throttle_write));
                check_field("throttle", 64'(want.throttle), 64'(o_out_item.throttle));
                check_field("alarm_op", 64'(want.alarm_op), 64'(o_out_item.alarm_op));
                check_field("alarm_delay", 64'(want.alarm_delay),
                            64'(o_out_item.alarm_delay));
                check_field("led_write", 64'(want.led_write), 64'(o_out_item.led_write));
                check_field("led_level", 64'(want.led_level), 64'(o_out_item.led_level));
            end
        end
    end

    initial begin
        reset_schedule();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_actions();
        test_field_extremes();
        test_start_stop();
        test_phase_cycle();
        test_odd_periods();
        test_watchdog();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        // Let the last results out, then wait out the longest latency
        i_in_valid <= 1'b0;
        for (int w = 0; w < 20000 && expected_results.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived, expected %h actual none",
                     $time, expected_results.size(), expected_results[0]);
            mismatch_count++;
        end

        $display("Sent %0d items, checked %0d results, %0d register writes.",
                 items_sent, results_seen, cfg_writes);
        $display("Scheduler starts %0d, phase resyncs %0d, shutdowns %0d, mismatches %0d.",
                 starts_seen, resyncs_seen, shutdowns_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
